### rtl/core/magnetic_disturbance_detector_defines.svh
// assertion macros for the magnetic disturbance detector
`ifndef MAGNETIC_DISTURBANCE_DETECTOR_DEFINES_SVH
`define MAGNETIC_DISTURBANCE_DETECTOR_DEFINES_SVH

// property checked on every rising edge outside reset
`define MDD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define MDD_ASSERT_NEVER(label, cond, msg) \
	`MDD_ASSERT(label, !(cond), msg)

`endif

### rtl/core/mdd_pkg.sv
// shared types and constants of the magnetic disturbance detector
`default_nettype none
package mdd_pkg;

	localparam int UNITS_DEF = 8;
	localparam int IDX_W     = 3;
	localparam int FIELD_W   = 16;
	localparam int MAG_W     = 16;
	localparam int REF_FRAC  = 8;
	localparam int REF_W     = MAG_W + REF_FRAC;
	localparam int FRAC_W    = 16;
	localparam int SUM_W     = 2 * FIELD_W;
	localparam int PROD_W    = REF_W + FRAC_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_FRACTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_WEIGHT    = 2'd1;

	localparam logic [FRAC_W-1:0] CHANGE_FRACTION_RST = 16'd13107;
	localparam logic [FRAC_W-1:0] ADAPT_WEIGHT_RST    = 16'd1311;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQRT,
		ST_MULT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             disturbed;
		logic [REF_W-1:0] ref_new;
	} upd_result_t;

endpackage
`default_nettype wire

### rtl/core/mdd_sqsum.sv
// bit-serial sum of squares of the three field components
`default_nettype none
module mdd_sqsum import mdd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [FIELD_W-1:0] field_x,
	input  logic signed [FIELD_W-1:0] field_y,
	input  logic signed [FIELD_W-1:0] field_z,
	output logic                      done,
	output logic [SUM_W-1:0]          sum
);

	localparam int CNT_W = $clog2(FIELD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FIELD_W - 1);

	function automatic logic [FIELD_W-1:0] abs_val(input logic [FIELD_W-1:0] v);
		return v[FIELD_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] mcx_q, mcy_q, mcz_q;
	logic [FIELD_W-1:0] mpx_q, mpy_q, mpz_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] pp;

	assign pp = (mpx_q[0] ? mcx_q : '0) + (mpy_q[0] ? mcy_q : '0) + (mpz_q[0] ? mcz_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcx_q <= SUM_W'(abs_val(field_x));
			mcy_q <= SUM_W'(abs_val(field_y));
			mcz_q <= SUM_W'(abs_val(field_z));
			mpx_q <= abs_val(field_x);
			mpy_q <= abs_val(field_y);
			mpz_q <= abs_val(field_z);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
			mcx_q <= mcx_q << 1;
			mcy_q <= mcy_q << 1;
			mcz_q <= mcz_q << 1;
			mpx_q <= mpx_q >> 1;
			mpy_q <= mpy_q >> 1;
			mpz_q <= mpz_q >> 1;
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule
`default_nettype wire

### rtl/core/mdd_isqrt.sv
// restoring integer square root, one root bit per cycle
`default_nettype none
module mdd_isqrt import mdd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] radicand,
	output logic             done,
	output logic [MAG_W-1:0] root
);

	localparam int CNT_W = $clog2(MAG_W);
	localparam int REM_W = MAG_W + 2;
	localparam int SH_W  = REM_W + 2;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [MAG_W-1:0] root_q;
	logic [SH_W-1:0]  rem_sh;
	logic [SH_W-1:0]  trial;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_sh);
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

### rtl/core/mdd_refupd.sv
// serial threshold and weight products, disturbance test and reference step
`default_nettype none
module mdd_refupd import mdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [REF_W-1:0]  target,
	input  logic [REF_W-1:0]  ref_in,
	input  logic [FRAC_W-1:0] change_fraction,
	input  logic [FRAC_W-1:0] adapt_weight,
	output logic              done,
	output upd_result_t       result
);

	localparam int CNT_W = $clog2(FRAC_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REF_W-1:0]  ref_q;
	logic [REF_W-1:0]  diff_q;
	logic              below_q;
	logic [PROD_W-1:0] mc1_q, mc2_q;
	logic [FRAC_W-1:0] mp1_q, mp2_q;
	logic [PROD_W-1:0] p1_q, p2_q;
	logic              below;
	logic              exceed;
	logic [REF_W-1:0]  step;

	assign below = target < ref_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ref_q   <= ref_in;
			below_q <= below;
			diff_q  <= below ? (ref_in - target) : (target - ref_in);
			mc1_q   <= PROD_W'(ref_in);
			mc2_q   <= PROD_W'(below ? (ref_in - target) : (target - ref_in));
			mp1_q   <= change_fraction;
			mp2_q   <= adapt_weight;
			p1_q    <= '0;
			p2_q    <= '0;
		end else if (busy_q) begin
			p1_q  <= p1_q + (mp1_q[0] ? mc1_q : '0);
			p2_q  <= p2_q + (mp2_q[0] ? mc2_q : '0);
			mc1_q <= mc1_q << 1;
			mc2_q <= mc2_q << 1;
			mp1_q <= mp1_q >> 1;
			mp2_q <= mp2_q >> 1;
		end
	end

	// diff * 2^16 against fraction * ref, then a truncated weighted step
	assign exceed = {diff_q, {FRAC_W{1'b0}}} > p1_q;
	assign step   = p2_q[PROD_W-1:FRAC_W];

	always_comb begin
		result.disturbed = exceed;
		if (exceed) begin
			result.ref_new = ref_q;
		end else if (below_q) begin
			result.ref_new = ref_q - step;
		end else begin
			result.ref_new = ref_q + step;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

### rtl/core/magnetic_disturbance_detector.sv
// top level of the magnetic disturbance detector
`default_nettype none
`include "magnetic_disturbance_detector_defines.svh"
// Takes one three-axis magnetometer sample (Q12.4) per request for one of UNITS
// sensors and returns one result: the floor square root of x*x+y*y+z*z, a
// disturbance flag, a first-reading flag and the sensor's reference level after
// the update (magnitude with 8 fraction bits). A request passes in turn through
// the bit-serial squarer, the one-bit-per-cycle square root and the serial
// threshold and weight multipliers, then into the output register; no new
// request is taken until its result has been loaded there. The result sits in
// an output register, so the next request is taken while a finished result
// still waits. Sensor references start at zero after reset through per-entry
// valid bits, with no clearing pass. A sensor index at or above UNITS still
// reports the magnitude, leaves the references alone and returns zero flags
// and reference. Registers change_fraction (index 0) and adapt_weight
// (index 1) are to be written only while the block is idle, which the block
// itself does not enforce; writes to other indexes are dropped.
module magnetic_disturbance_detector import mdd_pkg::*; #(
	parameter int UNITS = UNITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// sample request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [IDX_W-1:0]          sensor_index,
	input  logic signed [FIELD_W-1:0] field_x,
	input  logic signed [FIELD_W-1:0] field_y,
	input  logic signed [FIELD_W-1:0] field_z,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      disturbed,
	output logic                      first_reading,
	output logic [MAG_W-1:0]          magnitude,
	output logic [REF_W-1:0]          reference_out,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [FRAC_W-1:0]         cfg_data
);

	localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;

	// configuration registers
	logic [FRAC_W-1:0] change_fraction_q;
	logic [FRAC_W-1:0] adapt_weight_q;

	// control
	state_t            state_q, state_d;
	logic              in_accept;
	logic              out_free;
	logic              fin_load;
	logic [IDX_W-1:0]  idx_q;
	logic [AW-1:0]     addr_q;
	logic              in_range;

	// serial units
	logic              sq_done;
	logic [SUM_W-1:0]  sq_sum;
	logic              rt_done;
	logic [MAG_W-1:0]  rt_root;
	logic              upd_done;
	upd_result_t       upd_res;
	logic [REF_W-1:0]  target;

	// reference store: memory plus a valid bit per entry
	logic [REF_W-1:0]  mem_q [UNITS];
	logic [UNITS-1:0]  valid_q;
	logic [REF_W-1:0]  ref_rd_q;
	logic [REF_W-1:0]  ref_cur;
	logic              mem_we;

	// result fields before the output register
	logic              first_d;
	logic              dist_d;
	logic [REF_W-1:0]  ref_out_d;

	// output register
	logic              out_valid_q;
	logic              disturbed_q;
	logic              first_q;
	logic [MAG_W-1:0]  mag_q;
	logic [REF_W-1:0]  ref_out_q;
	logic [REF_W-1:0]  mag_ref;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign fin_load  = (state_q == ST_FIN) && out_free;
	assign in_range  = 32'(idx_q) < 32'(UNITS);
	assign target    = {rt_root, {REF_FRAC{1'b0}}};
	// entries never written since reset read as zero
	assign ref_cur   = valid_q[addr_q] ? ref_rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_fraction_q <= CHANGE_FRACTION_RST;
			adapt_weight_q    <= ADAPT_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANGE_FRACTION: change_fraction_q <= cfg_data;
				CFG_ADAPT_WEIGHT:    adapt_weight_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: square, root, multiply, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_accept) state_d = ST_SQUARE;
			ST_SQUARE: if (sq_done)   state_d = ST_SQRT;
			ST_SQRT:   if (rt_done)   state_d = ST_MULT;
			ST_MULT:   if (upd_done)  state_d = ST_FIN;
			ST_FIN:    if (out_free)  state_d = ST_IDLE;
			default:                  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_q  <= sensor_index;
			addr_q <= AW'(sensor_index);
		end
	end

	mdd_sqsum u_sqsum (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_accept),
		.field_x (field_x),
		.field_y (field_y),
		.field_z (field_z),
		.done    (sq_done),
		.sum     (sq_sum)
	);

	mdd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_done),
		.radicand (sq_sum),
		.done     (rt_done),
		.root     (rt_root)
	);

	mdd_refupd u_refupd (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (rt_done),
		.target          (target),
		.ref_in          (ref_cur),
		.change_fraction (change_fraction_q),
		.adapt_weight    (adapt_weight_q),
		.done            (upd_done),
		.result          (upd_res)
	);

	// zero reference means first reading: load the magnitude, no disturbance
	always_comb begin
		first_d   = in_range && (ref_cur == '0);
		dist_d    = in_range && !first_d && upd_res.disturbed;
		ref_out_d = '0;
		if (in_range) begin
			ref_out_d = first_d ? target : upd_res.ref_new;
		end
	end

	assign mem_we = fin_load && in_range;

	// store read is registered; the address holds for the whole request
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= ref_out_d;
		end
		ref_rd_q <= mem_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	// output register parts the result channel from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			disturbed_q <= dist_d;
			first_q     <= first_d;
			mag_q       <= rt_root;
			ref_out_q   <= ref_out_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign disturbed     = disturbed_q;
	assign first_reading = first_q;
	assign magnitude     = mag_q;
	assign reference_out = ref_out_q;

	// reported magnitude in reference format
	assign mag_ref = {magnitude, {REF_FRAC{1'b0}}};

	`MDD_ASSERT(a_accept_starts, in_accept |=> (state_q == ST_SQUARE), "accept did not start")
	`MDD_ASSERT_NEVER(a_flags_excl, out_valid && disturbed && first_reading, "both flags set")
	`MDD_ASSERT(a_write_in_range, mem_we |-> in_range, "reference write out of range")
	`MDD_ASSERT(a_first_loads_mag, (out_valid && first_reading) |-> (reference_out == mag_ref), "bad load")
	`MDD_ASSERT(a_root_in_sqrt, rt_done |-> (state_q == ST_SQRT), "root done outside root phase")

endmodule
`default_nettype wire

### tb/sv/tb_magnetic_disturbance_detector.sv
// self-checking testbench of the magnetic disturbance detector
`default_nettype none
module tb_magnetic_disturbance_detector;
	import mdd_pkg::*;

	localparam int DUT_UNITS     = UNITS_DEF;
	localparam int PHASE_ITEMS   = 235;
	localparam int SETTLE_CYCLES = 60;

	// register indexes past the two real registers, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic [IDX_W-1:0]   sensor;
		logic [FIELD_W-1:0] fx;
		logic [FIELD_W-1:0] fy;
		logic [FIELD_W-1:0] fz;
	} field_sample_t;

	typedef struct packed {
		logic             disturbed;
		logic             first_reading;
		logic [MAG_W-1:0] magnitude;
		logic [REF_W-1:0] level;
	} reading_t;

	typedef struct packed {
		row_kind_t            kind;
		field_sample_t        sample;
		logic                 typed;
		reading_t             reading;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [FRAC_W-1:0]    reg_value;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [IDX_W-1:0]          sensor_index = '0;
	logic signed [FIELD_W-1:0] field_x = '0;
	logic signed [FIELD_W-1:0] field_y = '0;
	logic signed [FIELD_W-1:0] field_z = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      disturbed;
	logic                      first_reading;
	logic [MAG_W-1:0]          magnitude;
	logic [REF_W-1:0]          reference_out;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [FRAC_W-1:0]         cfg_data = '0;

	// own copy of the block's state and registers
	logic [REF_W-1:0]  sensor_level [DUT_UNITS];
	logic [FRAC_W-1:0] change_fraction_now;
	logic [FRAC_W-1:0] adapt_weight_now;

	reading_t  pending_readings [$];
	stim_row_t stim_rows [$];
	int        sensor_nominal [DUT_UNITS][3];
	int        fault_count = 0;
	int        burst_left = 0;
	bit        hold_off_req = 1'b0;

	magnetic_disturbance_detector #(.UNITS(DUT_UNITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sensor_index(sensor_index),
		.field_x(field_x),
		.field_y(field_y),
		.field_z(field_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.disturbed(disturbed),
		.first_reading(first_reading),
		.magnitude(magnitude),
		.reference_out(reference_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root of x*x+y*y+z*z, one result bit per pass
	function automatic logic [MAG_W-1:0] field_magnitude(field_sample_t s);
		longint           sum;
		longint           comp;
		longint           trial;
		logic [MAG_W-1:0] root;
		comp = longint'($signed(s.fx));
		sum = comp * comp;
		comp = longint'($signed(s.fy));
		sum += comp * comp;
		comp = longint'($signed(s.fz));
		sum += comp * comp;
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = longint'(root) | (longint'(1) << b);
			if (trial * trial <= sum)
				root = MAG_W'(trial);
		end
		return root;
	endfunction

	// magnitude, threshold test and reference update for one request
	function automatic reading_t detect_disturbance(field_sample_t s);
		reading_t          r;
		logic [REF_W-1:0]  target;
		logic [REF_W-1:0]  level;
		logic [REF_W-1:0]  diff;
		logic [REF_W-1:0]  pull;
		logic [PROD_W-1:0] scaled_diff;
		logic [PROD_W-1:0] allowed;
		logic              below;
		r = '0;
		r.magnitude = field_magnitude(s);
		// sensors past the configured count only report the magnitude
		if (int'(s.sensor) >= DUT_UNITS)
			return r;
		target = {r.magnitude, {REF_FRAC{1'b0}}};
		level = sensor_level[s.sensor];
		if (level == '0) begin
			level = target;
			r.first_reading = 1'b1;
		end else begin
			below = target < level;
			diff = below ? level - target : target - level;
			scaled_diff = PROD_W'(diff) << FRAC_W;
			allowed = PROD_W'(change_fraction_now) * PROD_W'(level);
			r.disturbed = scaled_diff > allowed;
			if (!r.disturbed) begin
				pull = REF_W'((PROD_W'(diff) * PROD_W'(adapt_weight_now)) >> FRAC_W);
				level = below ? level - pull : level + pull;
			end
		end
		sensor_level[s.sensor] = level;
		r.level = level;
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_field(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return FIELD_W'(v);
	endfunction

	// random component whose size spans small to half scale
	function automatic int random_component();
		int sh;
		sh = $urandom_range(3, 15);
		return int'($urandom_range(0, (1 << sh) - 1)) - (1 << (sh - 1));
	endfunction

	// mostly steady fields around a per-sensor nominal, plus jumps and noise
	function automatic field_sample_t next_field_sample();
		field_sample_t s;
		int            pick;
		int            u;
		int            amp;
		int            delta;
		int            c [3];
		pick = $urandom_range(0, 99);
		s.sensor = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		u = int'(s.sensor) % DUT_UNITS;
		for (int k = 0; k < 3; k++) begin
			if (pick < 55) begin
				// small noise, the reference tracks
				amp = 1 << $urandom_range(0, 6);
				c[k] = sensor_nominal[u][k] + int'($urandom_range(0, 2 * amp)) - amp;
			end else if (pick < 72) begin
				// relative step around the threshold
				delta = int'($urandom_range(0, 160)) - 80;
				c[k] = sensor_nominal[u][k] + (sensor_nominal[u][k] * delta) / 256;
			end else if (pick < 80) begin
				// the sensor moves to a new field
				sensor_nominal[u][k] = random_component();
				c[k] = sensor_nominal[u][k];
			end else if (pick < 90) begin
				c[k] = int'($urandom_range(0, 65535)) - 32768;
			end else if (pick < 95) begin
				case ($urandom_range(0, 4))
					0: c[k] = -32768;
					1: c[k] = 32767;
					2: c[k] = -1;
					3: c[k] = 1;
					default: c[k] = 0;
				endcase
			end else begin
				c[k] = 0;
			end
		end
		s.fx = clamp_field(c[0]);
		s.fy = clamp_field(c[1]);
		s.fz = clamp_field(c[2]);
		return s;
	endfunction

	function automatic void add_sample(int sensor, int x, int y, int z);
		stim_row_t row;
		row = '0;
		row.kind = ROW_SAMPLE;
		row.sample = '{IDX_W'(sensor), FIELD_W'(x), FIELD_W'(y), FIELD_W'(z)};
		stim_rows.push_back(row);
	endfunction

	// sample row whose result is typed in
	function automatic void add_known(int sensor, int x, int y, int z,
			bit dist_flag, bit first_flag, int mag, int level);
		add_sample(sensor, x, y, z);
		stim_rows[$].typed = 1'b1;
		stim_rows[$].reading = '{dist_flag, first_flag, MAG_W'(mag), REF_W'(level)};
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, int value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_index = idx;
		row.reg_value = FRAC_W'(value);
		stim_rows.push_back(row);
	endfunction

	// offer one request and hold it until taken; cfg_we drops with it
	task automatic send_sample(field_sample_t s, logic typed, reading_t known);
		reading_t predicted;
		in_valid <= 1'b1;
		cfg_we <= 1'b0;
		sensor_index <= s.sensor;
		field_x <= s.fx;
		field_y <= s.fy;
		field_z <= s.fz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = detect_disturbance(s);
		pending_readings.push_back(typed ? known : predicted);
	endtask

	// bursts of requests with gaps of random length between them
	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// registers change only once every result is back
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_CHANGE_FRACTION: change_fraction_now = value;
			CFG_ADAPT_WEIGHT: adapt_weight_now = value;
			default: ;
		endcase
	endtask

	task automatic check_reading();
		reading_t got;
		reading_t want;
		got = '{disturbed, first_reading, magnitude, reference_out};
		if (pending_readings.size() == 0) begin
			fault_count++;
			if (fault_count <= 10)
				$display("unexpected result: dist=%0b first=%0b mag=%0d level=%0d",
					got.disturbed, got.first_reading, got.magnitude, got.level);
			return;
		end
		want = pending_readings.pop_front();
		if (got.disturbed !== want.disturbed || got.first_reading !== want.first_reading
				|| got.magnitude !== want.magnitude || got.level !== want.level) begin
			fault_count++;
			if (fault_count <= 10)
				$display("mismatch: dist %0b/%0b first %0b/%0b mag %0d/%0d level %0d/%0d",
					want.disturbed, got.disturbed, want.first_reading, got.first_reading,
					want.magnitude, got.magnitude, want.level, got.level);
		end
	endtask

	// result side: rotating ready pattern per stretch, long hold-off on demand
	initial begin : result_sink
		int         stretch;
		int         hold_left;
		logic [7:0] ready_pattern;
		stretch = 0;
		hold_left = 0;
		ready_pattern = '1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_reading();
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = $urandom_range(300, 600);
			end
			if (stretch == 0) begin
				stretch = $urandom_range(20, 200);
				if ($urandom_range(0, 3) == 0)
					ready_pattern = '1;
				else
					ready_pattern = 8'($urandom_range(1, 255));
			end
			stretch--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
			end
		end
	end

	initial begin
		#15_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [FRAC_W-1:0] cf_setting;
		logic [FRAC_W-1:0] aw_setting;
		field_sample_t     s;
		for (int u = 0; u < DUT_UNITS; u++) begin
			sensor_level[u] = '0;
			for (int k = 0; k < 3; k++)
				sensor_nominal[u][k] = random_component();
		end
		change_fraction_now = CHANGE_FRACTION_RST;
		adapt_weight_now = ADAPT_WEIGHT_RST;

		// first reading, repeat, full-scale fields
		add_known(0, 48, 64, 0, 0, 1, 80, 20480);
		add_known(0, 48, 64, 0, 0, 0, 80, 20480);
		add_known(1, -32768, -32768, -32768, 0, 1, 56755, 14529280);
		add_sample(1, 32767, 32767, 32767);
		// zero magnitude leaves the sensor without a reading
		add_known(2, 0, 0, 0, 0, 1, 0, 0);
		add_known(2, 0, 0, 16, 0, 1, 16, 4096);
		// tenfold jump is a disturbance and freezes the reference
		add_known(0, 480, 640, 0, 1, 0, 800, 20480);
		add_known(0, -48, -64, 0, 0, 0, 80, 20480);
		add_sample(3, 32767, -32768, 0);
		add_known(4, -1, -1, -1, 0, 1, 1, 256);
		add_sample(5, 21845, 21845, 21845);
		add_sample(6, -21846, -21846, -21846);
		add_known(7, 1, 0, 0, 0, 1, 1, 256);
		add_sample(0, 52, 64, 0);
		// zero threshold: any difference is a disturbance
		add_write(CFG_CHANGE_FRACTION, 0);
		add_sample(0, 48, 64, 0);
		add_sample(0, 48, 64, 0);
		// zero weight: the reference stays put
		add_write(CFG_ADAPT_WEIGHT, 0);
		add_write(CFG_CHANGE_FRACTION, 65535);
		add_sample(0, 56, 64, 0);
		add_sample(0, 0, 0, 0);
		// writes past the register file are dropped
		add_write(CFG_SPARE_A, 65535);
		add_write(CFG_SPARE_B, 0);
		add_sample(0, 60, 64, 8);
		add_write(CFG_ADAPT_WEIGHT, 65535);
		add_sample(1, 32767, 32767, 32767);
		add_sample(1, 1000, 0, 0);
		add_write(CFG_CHANGE_FRACTION, CHANGE_FRACTION_RST);
		add_write(CFG_ADAPT_WEIGHT, ADAPT_WEIGHT_RST);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 40);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE) begin
				drain_requests();
				write_register(stim_rows[i].reg_index, stim_rows[i].reg_value);
			end else begin
				send_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].reading);
				pace_sender();
			end
		end

		// random phases over register settings, extremes included
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin cf_setting = CHANGE_FRACTION_RST; aw_setting = ADAPT_WEIGHT_RST; end
				1: begin cf_setting = '0; aw_setting = '0; end
				2: begin cf_setting = '1; aw_setting = '1; end
				3: begin cf_setting = '0; aw_setting = '1; end
				4: begin cf_setting = '1; aw_setting = '0; end
				7: begin cf_setting = CHANGE_FRACTION_RST; aw_setting = 16'd6554; end
				default: begin
					cf_setting = FRAC_W'($urandom_range(0, 65535));
					aw_setting = FRAC_W'($urandom_range(0, 65535));
				end
			endcase
			drain_requests();
			write_register(CFG_CHANGE_FRACTION, cf_setting);
			write_register(CFG_ADAPT_WEIGHT, aw_setting);
			write_register(p[0] ? CFG_SPARE_B : CFG_SPARE_A, FRAC_W'($urandom_range(0, 65535)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long result stall while requests keep coming
				if (i == PHASE_ITEMS / 2)
					hold_off_req = 1'b1;
				s = next_field_sample();
				send_sample(s, 1'b0, '0);
				pace_sender();
			end
		end

		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
